// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// File: rtl/mgr_pkg.sv
// Shared types and constants of the minimum gap and range tracker.
`timescale 1ns / 1ps

package mgr_pkg;

  localparam int VALUE_W = 32;
  localparam int SPAN_W  = 32;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;
  localparam logic [VALUE_W-1:0] SIGN_FLIP = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_GAP  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic step;    // an item is taken this cycle
    logic store;   // the item is stored (count below the capacity limit)
    logic occ;     // this cell holds a value
    logic at_end;  // this cell is the first free one
  } cell_ctrl_t;

endpackage

// File: rtl/mgr_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps

interface mgr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mgr_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface mgr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic                          spans_valid;
  logic [mgr_pkg::COUNT_W-1:0]   held_count;
  logic [mgr_pkg::SPAN_W-1:0]    shortest_span;
  logic [mgr_pkg::SPAN_W-1:0]    longest_span;

  modport source (output valid, output accepted, output spans_valid, output held_count,
                  output shortest_span, output longest_span, input ready);
  modport sink   (input valid, input accepted, input spans_valid, input held_count,
                  input shortest_span, input longest_span, output ready);
endinterface

// File: rtl/min_gap_and_range_tracker.sv
// Top level of the minimum gap and range tracker: cell row, sequencer and result register.
`timescale 1ns / 1ps

// The block keeps a bounded set of signed 32-bit numbers in sorted order in a
// row of DEPTH cells. Each item on the feed channel offers one number; it is
// stored when fewer numbers are held than min(capacity, DEPTH), else rejected.
// Every item yields one result item on the result channel: the accept flag,
// the count held, the smallest gap between sorted neighbors and the range
// (largest minus smallest). Both spans read zero until two numbers are held.
// Insertion happens in the cycle the item is taken: all cells compare against
// the new number at once and the larger ones move one cell right. The next
// cycle picks out the two new neighbor gaps and the largest value; the finish
// step folds the gaps into the running minimum and loads the result register.
// An item can be taken in the finish step of the item before it, so the new
// item is inserted in the cells while the one before it loads the result.
// The capacity register is written through cfg_we/cfg_data; the user must do this only
// while idle, as the block has no guard for it. Reset empties the set, restores the
// capacity to 64 and the minimum gap to all ones; feed.ready stays low in the cycle
// after reset. When the result register is full and not taken, the finishing item waits
// and no new item is taken until the register frees.

module min_gap_and_range_tracker #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mgr_pkg::COUNT_W-1:0]   cfg_data,
  mgr_in_if.sink                        feed,
  mgr_out_if.source                     result
);

  localparam int HW = $clog2(DEPTH + 1);
  localparam int LW = (HW > mgr_pkg::COUNT_W) ? HW : mgr_pkg::COUNT_W;

  mgr_pkg::state_t state;
  logic                          live;
  logic [mgr_pkg::COUNT_W-1:0]   cap;
  logic [HW-1:0]                 held;
  logic [mgr_pkg::SPAN_W-1:0]    min_gap;
  logic                          acc_q;
  logic [mgr_pkg::SPAN_W-1:0]    lg_q;
  logic [mgr_pkg::SPAN_W-1:0]    rg_q;
  logic                          lv_q;
  logic                          rv_q;
  logic [mgr_pkg::VALUE_W-1:0]   last_q;

  logic                          out_valid;
  logic                          out_accepted;
  logic                          out_spans_valid;
  logic [mgr_pkg::COUNT_W-1:0]   out_held_count;
  logic [mgr_pkg::SPAN_W-1:0]    out_shortest;
  logic [mgr_pkg::SPAN_W-1:0]    out_longest;

  logic                          slot_free;
  logic                          take;
  logic                          finish;
  logic                          acc;
  logic [LW-1:0]                 cap_ext;
  logic [LW-1:0]                 lim;
  logic [LW-1:0]                 held_ext;
  logic [HW-1:0]                 held_last;
  logic [mgr_pkg::VALUE_W-1:0]   flipped;

  logic [mgr_pkg::SPAN_W-1:0]    lg;
  logic [mgr_pkg::SPAN_W-1:0]    rg;
  logic                          lv;
  logic                          rv;
  logic [mgr_pkg::VALUE_W-1:0]   last_val;
  logic [mgr_pkg::SPAN_W-1:0]    min_a;
  logic [mgr_pkg::SPAN_W-1:0]    min_gap_next;
  logic                          spans_ok;

  mgr_pkg::cell_ctrl_t           ctrl     [DEPTH];
  logic                          cell_gt  [DEPTH];
  logic [mgr_pkg::VALUE_W-1:0]   cell_val [DEPTH];
  logic                          cell_ins [DEPTH];
  logic [mgr_pkg::SPAN_W-1:0]    cell_gap [DEPTH];

  // Handshake and acceptance decision.
  assign slot_free  = !out_valid || result.ready;
  assign feed.ready = live && ((state == mgr_pkg::ST_IDLE) ||
                               ((state == mgr_pkg::ST_FIN) && slot_free));
  assign take       = feed.valid && feed.ready;
  assign finish     = (state == mgr_pkg::ST_FIN) && slot_free;

  // The effective capacity saturates at the row length.
  assign cap_ext  = LW'(cap);
  assign lim      = (cap_ext < LW'(DEPTH)) ? cap_ext : LW'(DEPTH);
  assign held_ext = LW'(held);
  assign acc      = held_ext < lim;
  assign flipped  = feed.value ^ mgr_pkg::SIGN_FLIP;

  // The cell row. Each cell hands its compare flag and value to its right neighbor.
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                        left_gt;
      logic [mgr_pkg::VALUE_W-1:0] left_val;

      if (gi == 0) begin : g_first
        assign left_gt  = 1'b0;
        assign left_val = '0;
      end else begin : g_rest
        assign left_gt  = cell_gt[gi-1];
        assign left_val = cell_val[gi-1];
      end

      assign ctrl[gi].step   = take;
      assign ctrl[gi].store  = acc;
      assign ctrl[gi].occ    = HW'(gi) < held;
      assign ctrl[gi].at_end = HW'(gi) == held;

      mgr_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl[gi]),
        .new_val  (flipped),
        .left_gt  (left_gt),
        .left_val (left_val),
        .gt       (cell_gt[gi]),
        .val      (cell_val[gi]),
        .ins      (cell_ins[gi]),
        .gap_left (cell_gap[gi])
      );
    end
  endgenerate

  // After an insert exactly one cell carries the insert mark. The gap to its
  // left neighbor and the gap from it to its right neighbor are the only new
  // neighbor pairs; both are picked out with one-hot selects. A rejected item
  // leaves every mark clear, so neither gap counts.
  assign held_last = held - HW'(1);

  always_comb begin
    lg       = '0;
    rg       = '0;
    lv       = 1'b0;
    rv       = 1'b0;
    last_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (HW'(i) == held_last) begin
        last_val = last_val | cell_val[i];
      end
      if (i > 0) begin
        if (cell_ins[i]) begin
          lg = lg | cell_gap[i];
          lv = 1'b1;
        end
        if (cell_ins[i-1] && (HW'(i) < held)) begin
          rg = rg | cell_gap[i];
          rv = 1'b1;
        end
      end
    end
  end

  // Fold the new gaps into the running minimum.
  assign min_a        = (lv_q && (lg_q < min_gap)) ? lg_q : min_gap;
  assign min_gap_next = (rv_q && (rg_q < min_a)) ? rg_q : min_a;
  assign spans_ok     = held >= HW'(2);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mgr_pkg::ST_IDLE;
      live  <= 1'b0;
    end else begin
      live <= 1'b1;
      unique case (state)
        mgr_pkg::ST_IDLE: begin
          if (take) begin
            state <= mgr_pkg::ST_GAP;
          end
        end
        mgr_pkg::ST_GAP: begin
          state <= mgr_pkg::ST_FIN;
        end
        mgr_pkg::ST_FIN: begin
          if (take) begin
            state <= mgr_pkg::ST_GAP;
          end else if (finish) begin
            state <= mgr_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= mgr_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Configuration, count and running minimum.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap     <= mgr_pkg::CAP_RESET;
      held    <= '0;
      min_gap <= '1;
      acc_q   <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (take) begin
        acc_q <= acc;
        if (acc) begin
          held <= held + HW'(1);
        end
      end
      if (finish) begin
        min_gap <= min_gap_next;
      end
    end
  end

  // Gap stage registers.
  always_ff @(posedge clk) begin
    if (state == mgr_pkg::ST_GAP) begin
      lg_q   <= lg;
      rg_q   <= rg;
      lv_q   <= lv;
      rv_q   <= rv;
      last_q <= last_val;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_accepted    <= acc_q;
      out_spans_valid <= spans_ok;
      out_held_count  <= held_ext[mgr_pkg::COUNT_W-1:0];
      out_shortest    <= spans_ok ? min_gap_next : '0;
      out_longest     <= spans_ok ? (last_q - cell_val[0]) : '0;
    end
  end

  assign result.valid         = out_valid;
  assign result.accepted      = out_accepted;
  assign result.spans_valid   = out_spans_valid;
  assign result.held_count    = out_held_count;
  assign result.shortest_span = out_shortest;
  assign result.longest_span  = out_longest;

endmodule

// File: rtl/mgr_cell.sv
// One slot of the sorted insertion row: holds a value and shifts it right on insert.
`timescale 1ns / 1ps

module mgr_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  mgr_pkg::cell_ctrl_t            ctrl,
  input  logic [mgr_pkg::VALUE_W-1:0]    new_val,
  input  logic                           left_gt,
  input  logic [mgr_pkg::VALUE_W-1:0]    left_val,
  output logic                           gt,
  output logic [mgr_pkg::VALUE_W-1:0]    val,
  output logic                           ins,
  output logic [mgr_pkg::SPAN_W-1:0]     gap_left
);

  logic take_new;

  // Values are kept in offset binary, so an unsigned compare orders them.
  assign gt       = ctrl.occ && (val > new_val);
  assign take_new = !left_gt && (gt || ctrl.at_end);
  assign gap_left = val - left_val;

  always_ff @(posedge clk) begin
    if (ctrl.step && ctrl.store) begin
      if (left_gt) begin
        val <= left_val;
      end else if (take_new) begin
        val <= new_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ins <= 1'b0;
    end else if (ctrl.step) begin
      ins <= ctrl.store && take_new;
    end
  end

endmodule

// File: rtl/mgr_checker.sv
// Port-level checks of the minimum gap and range tracker and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mgr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          accepted,
  input logic                          spans_valid,
  input logic [mgr_pkg::COUNT_W-1:0]   held_count,
  input logic [mgr_pkg::SPAN_W-1:0]    shortest_span,
  input logic [mgr_pkg::SPAN_W-1:0]    longest_span
);

  logic in_take;
  logic out_stall;
  logic spans_zero;
  logic [2+mgr_pkg::COUNT_W+2*mgr_pkg::SPAN_W-1:0] out_fields;

  assign in_take    = in_valid && in_ready;
  assign out_stall  = out_valid && !out_ready;
  assign out_fields = {accepted, spans_valid, held_count, shortest_span, longest_span};
  assign spans_zero = (shortest_span == '0) && (longest_span == '0) &&
                      (held_count < mgr_pkg::COUNT_W'(2));

  // A stalled result stays put.
  `ASSERT_NEXT(a_stall_hold, clk, rst, out_stall, out_valid && $stable(out_fields))

  // Ready drops after each taken item, so items are never taken back to back.
  `ASSERT_NEXT(a_two_cycles, clk, rst, in_take, !in_ready)

  // Spans read zero until two numbers are held.
  `ASSERT_SAME(a_spans_zero, clk, rst, out_valid && !spans_valid, spans_zero)

  // The smallest neighbor gap never exceeds the full range.
  `ASSERT_SAME(a_gap_in_range, clk, rst, out_valid && spans_valid, shortest_span <= longest_span)

endmodule

bind min_gap_and_range_tracker mgr_checker u_mgr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (feed.valid),
  .in_ready      (feed.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .accepted      (result.accepted),
  .spans_valid   (result.spans_valid),
  .held_count    (result.held_count),
  .shortest_span (result.shortest_span),
  .longest_span  (result.longest_span)
);

// File: sim/min_gap_and_range_tracker_test.sv
// Self-checking testbench for the minimum gap and range tracker.
`timescale 1ns / 1ps

// The testbench offers signed 32-bit numbers on the feed channel. For every
// number that the block takes, it predicts the result item: accept flag, count
// held, smallest neighbor gap and range. It keeps its own sorted copy of the
// set for this. A checker process compares each result item the block hands
// over with the oldest prediction, field by field.
//
// Only 64 numbers can ever be stored, and reset is applied once. So the run
// raises the capacity step by step while the set fills. Once the set is full,
// it keeps exercising the register: zero, the depth, values above the depth and
// random values. In that part every number is rejected, but each one still
// reports the current count and spans.

module min_gap_and_range_tracker_test;

  localparam int SET_DEPTH     = 64;
  localparam int RANDOM_ITEMS  = 950;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS    = 10_000_000;

  localparam logic signed [mgr_pkg::VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [mgr_pkg::VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [mgr_pkg::COUNT_W-1:0] CAP_NONE = 7'd0;
  localparam logic [mgr_pkg::COUNT_W-1:0] CAP_TOP  = 7'd127;

  // One result item as the block reports it.
  typedef struct packed {
    logic                        accepted;
    logic                        spans_valid;
    logic [mgr_pkg::COUNT_W-1:0] held_count;
    logic [mgr_pkg::SPAN_W-1:0]  shortest_span;
    logic [mgr_pkg::SPAN_W-1:0]  longest_span;
  } span_report_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [mgr_pkg::COUNT_W-1:0] cfg_data;
  logic                        rx_ready = 1'b0;

  mgr_in_if  feed ();
  mgr_out_if result ();

  assign result.ready = rx_ready;

  min_gap_and_range_tracker #(
    .DEPTH(SET_DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .feed    (feed),
    .result  (result)
  );

  // The testbench's own copy of the block's state. The set is kept sorted in
  // ascending signed order, the same way the block stores it.
  logic signed [mgr_pkg::VALUE_W-1:0] set_vals [SET_DEPTH];
  int unsigned                        set_count;
  logic [mgr_pkg::SPAN_W-1:0]         gap_floor;
  logic [mgr_pkg::COUNT_W-1:0]        cap_reg;

  span_report_t pending_reports [$];
  span_report_t want_report;
  int           fail_count;
  int           random_sent;
  int           burst_left;
  logic signed [mgr_pkg::VALUE_W-1:0] cluster_base;

  // Receiver stall pattern state.
  int stall_mode;
  int stall_phase_left;
  int stall_tick;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run always ends, even if a handshake hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("min_gap_and_range_tracker_test failed");
    $finish;
  end

  // Work out the result item for one number that the block has just taken.
  // A number is stored only while fewer are held than the capacity, and the
  // capacity saturates at the depth of the set. A rejected number leaves the
  // set alone and still reports the count and spans. Gaps are plain 32-bit
  // differences: the difference of two signed 32-bit numbers, taken modulo
  // 2**32, is their exact unsigned distance.
  function automatic span_report_t predict_insert(
    input logic signed [mgr_pkg::VALUE_W-1:0] v
  );
    span_report_t r;
    int unsigned  lim;
    int           pos;
    logic [mgr_pkg::SPAN_W-1:0] gap;
    r   = '0;
    lim = (cap_reg < SET_DEPTH) ? cap_reg : SET_DEPTH;
    r.accepted = (set_count < lim);
    if (r.accepted) begin
      pos = set_count;
      while (pos > 0 && set_vals[pos-1] > v) begin
        set_vals[pos] = set_vals[pos-1];
        pos--;
      end
      set_vals[pos] = v;
      // Only the two new neighbor pairs can lower the running minimum. A
      // split pair's gap is never smaller than the two new gaps that replace it.
      if (pos > 0) begin
        gap = v - set_vals[pos-1];
        if (gap < gap_floor) gap_floor = gap;
      end
      if (pos < set_count) begin
        gap = set_vals[pos+1] - v;
        if (gap < gap_floor) gap_floor = gap;
      end
      set_count++;
    end
    r.held_count = set_count[mgr_pkg::COUNT_W-1:0];
    if (set_count >= 2) begin
      r.spans_valid   = 1'b1;
      r.shortest_span = gap_floor;
      r.longest_span  = set_vals[set_count-1] - set_vals[0];
    end
    return r;
  endfunction

  // Clustered numbers to get small gaps, some repeats of held numbers to get
  // zero gaps, some extremes for the widest spans, and the rest, half of all
  // picks, spread over the whole 32-bit range.
  function automatic logic signed [mgr_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return cluster_base + mgr_pkg::VALUE_W'($urandom_range(0, 40));
      4: begin
        if (set_count > 0) return set_vals[$urandom_range(0, set_count - 1)];
        return $urandom();
      end
      default: return $urandom();
    endcase
  endfunction

  // Offer one number and wait until the block takes it. The sender works in
  // bursts. When a burst runs out, valid drops for a random gap before the
  // next number, so gaps land on every step of the block's work.
  task automatic send_value(input logic signed [mgr_pkg::VALUE_W-1:0] v);
    if (burst_left == 0) begin
      feed.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    feed.valid <= 1'b1;
    feed.value <= v;
    @(posedge clk);
    while (feed.ready !== 1'b1) @(posedge clk);
    pending_reports = {pending_reports, predict_insert(v)};
    burst_left--;
  endtask

  // Hold the sender back until every predicted result item has arrived.
  task automatic drain_results();
    feed.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // The capacity is changed only while the block is idle.
  task automatic write_capacity(input logic [mgr_pkg::COUNT_W-1:0] cap);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cap_reg = cap;
    cfg_we  <= 1'b0;
  endtask

  // The reset capacity takes the smallest number. A capacity of zero then
  // rejects the largest one.
  task automatic test_reset_and_zero_capacity();
    send_value(VAL_MIN);
    write_capacity(CAP_NONE);
    send_value(VAL_MAX);
  endtask

  // With the capacity at or below the count, numbers are rejected. Raising it
  // lets the two extremes form the widest possible span, and an equal number
  // brings the gap to zero. Lowering it below the count drops nothing.
  task automatic test_lowered_capacity();
    write_capacity(7'd1);
    send_value('0);
    write_capacity(7'd3);
    send_value(VAL_MAX);
    send_value(VAL_MAX);
    send_value(32'sd5);
    write_capacity(7'd2);
    send_value('1);
  endtask

  // Capacity above the depth. Numbers land next to both ends and in the
  // middle, with alternating bit patterns on both signs.
  task automatic test_saturated_capacity();
    logic signed [mgr_pkg::VALUE_W-1:0] picks [10];
    picks = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h5555_5555,
              32'hAAAA_AAAA, 32'sd100, 32'sd99, 32'sd101, 32'h8000_0001,
              32'h7FFF_FFFE};
    write_capacity(CAP_TOP);
    foreach (picks[i]) send_value(picks[i]);
  endtask

  // Fill the rest of the set in phases. Each phase raises the capacity above the
  // count, by up to six or, near the top, to the depth or beyond, and offers at
  // least as many numbers as fit. Now and then a phase lowers the capacity to or
  // below the count, and those numbers are turned away.
  task automatic test_random_fill();
    int n;
    int next_cap;
    while (set_count < SET_DEPTH) begin
      cluster_base = $urandom();
      if ($urandom_range(0, 4) == 0) begin
        write_capacity(mgr_pkg::COUNT_W'($urandom_range(0, set_count)));
        n = $urandom_range(1, 3);
      end else begin
        next_cap = set_count + $urandom_range(1, 6);
        if (next_cap >= SET_DEPTH) next_cap = $urandom_range(0, 1) ? SET_DEPTH : CAP_TOP;
        write_capacity(mgr_pkg::COUNT_W'(next_cap));
        n = next_cap - set_count + $urandom_range(0, 3);
      end
      repeat (n) begin
        send_value(pick_value());
        random_sent++;
      end
    end
  endtask

  // With the set full, every capacity setting must reject and keep reporting
  // the same count and spans.
  task automatic test_full_set();
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       write_capacity(CAP_NONE);
        1:       write_capacity(mgr_pkg::COUNT_W'(SET_DEPTH));
        2:       write_capacity(CAP_TOP);
        default: write_capacity(mgr_pkg::COUNT_W'($urandom_range(0, 127)));
      endcase
      repeat ($urandom_range(20, 60)) begin
        send_value($urandom());
        random_sent++;
      end
    end
  endtask

  // Receiver: the stall pattern changes from phase to phase, each of random length. It may
  // be always ready, random, periodically ready, or in long stalls.
  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode       = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(20, 200);
      stall_tick       = 0;
    end
    stall_phase_left--;
    stall_tick++;
    case (stall_mode)
      0:       rx_ready <= 1'b1;
      1:       rx_ready <= $urandom_range(0, 1);
      2:       rx_ready <= (stall_tick % 4) == 0;
      default: rx_ready <= (stall_tick % 16) >= 11;
    endcase
  end

  task automatic report_field(input string name, input logic [mgr_pkg::SPAN_W-1:0] want,
                              input logic [mgr_pkg::SPAN_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Checker: each result item taken is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst === 1'b0 && result.valid === 1'b1 && result.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result item with none expected, held_count %0d",
                 $time, result.held_count);
        fail_count++;
      end else begin
        want_report = pending_reports.pop_front();
        report_field("accepted", want_report.accepted, result.accepted);
        report_field("spans_valid", want_report.spans_valid, result.spans_valid);
        report_field("held_count", want_report.held_count, result.held_count);
        report_field("shortest_span", want_report.shortest_span, result.shortest_span);
        report_field("longest_span", want_report.longest_span, result.longest_span);
      end
    end
  end

  initial begin
    set_count        = 0;
    gap_floor        = '1;
    cap_reg          = mgr_pkg::CAP_RESET;
    fail_count       = 0;
    random_sent      = 0;
    burst_left       = 0;
    stall_phase_left = 0;
    cluster_base     = '0;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_data   <= '0;
    feed.valid <= 1'b0;
    feed.value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_and_zero_capacity();
    test_lowered_capacity();
    test_saturated_capacity();
    test_random_fill();
    test_full_set();

    // Let any stray result item show up before the verdict.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("min_gap_and_range_tracker_test passed");
    end else begin
      $display("min_gap_and_range_tracker_test failed");
    end
    $finish;
  end

endmodule
